// ----- src/lpfd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared constants and controller/datapath interface types for the
// length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfd_pkg;

  localparam int HEADER_BYTES_DEF = 28;
  localparam int LEN_OFFSET       = 4;
  localparam int BYTE_CNT_W       = 25;
  localparam int MAX_LEN_W        = 24;
  localparam int COUNT_W          = 32;

  localparam logic [31:0]          WIRE_MAGIC  = 32'h3143_5044;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 24'hFF_FFFF;

  localparam logic ERR_MAGIC  = 1'b0;
  localparam logic ERR_LENGTH = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic collect_wr;  // store a header byte
    logic check_ok;    // header accepted, latch length, start replay
    logic err_emit;    // load an error request into the output register
    logic rep_rd;      // read one header byte from the store
    logic rep_emit;    // load the read header byte into the output register
    logic pass_emit;   // pass one payload byte
  } lpfd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hdr_full;    // current byte completes the header
    logic hdr_good;    // magic and length checks pass
    logic out_free;    // output register can be loaded this cycle
    logic rep_last;    // replay index is on the final header byte
    logic short_frame; // frame ends with its header
    logic pass_last;   // current payload byte ends the frame
  } lpfd_sts_t;

endpackage

`default_nettype wire

// ----- src/lpfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpfd_ctrl
// Phase state machine: header collection, check, replay, payload pass and
// error discard. Drives datapath commands and the input ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_chunk_end,
  output logic                in_ready,
  input  lpfd_pkg::lpfd_sts_t sts,
  output lpfd_pkg::lpfd_cmd_t cmd
);

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_REP_RD  = 3'd2;
  localparam logic [2:0] ST_REP_WR  = 3'd3;
  localparam logic [2:0] ST_PASS    = 3'd4;
  localparam logic [2:0] ST_DISCARD = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       cend_r, cend_nxt;
  logic       in_fire;

  assign in_ready = (state_r == ST_COLLECT) | (state_r == ST_DISCARD) |
                    ((state_r == ST_PASS) & sts.out_free);
  assign in_fire  = in_valid & in_ready;

  always_comb begin
    state_nxt = state_r;
    cend_nxt  = cend_r;
    cmd       = '0;
    unique case (state_r)
      ST_COLLECT: begin
        cmd.collect_wr = in_fire;
        if (in_fire && sts.hdr_full) begin
          cend_nxt  = in_chunk_end;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.hdr_good) begin
          cmd.check_ok = 1'b1;
          state_nxt    = ST_REP_RD;
        end else if (sts.out_free) begin
          cmd.err_emit = 1'b1;
          // a bad header on a chunk end needs no discard
          state_nxt    = cend_r ? ST_COLLECT : ST_DISCARD;
        end
      end
      ST_REP_RD: begin
        cmd.rep_rd = 1'b1;
        state_nxt  = ST_REP_WR;
      end
      ST_REP_WR: begin
        if (sts.out_free) begin
          cmd.rep_emit = 1'b1;
          if (sts.rep_last) begin
            state_nxt = sts.short_frame ? ST_COLLECT : ST_PASS;
          end else begin
            state_nxt = ST_REP_RD;
          end
        end
      end
      ST_PASS: begin
        cmd.pass_emit = in_fire;
        if (in_fire && sts.pass_last) begin
          state_nxt = ST_COLLECT;
        end
      end
      ST_DISCARD: begin
        if (in_fire && in_chunk_end) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      cend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cend_r  <= cend_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/lpfd_dp.sv -----
// ----------------------------------------------------------------------------
// lpfd_dp
// Datapath: header store, length and magic capture, byte and frame counters,
// configuration register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_dp #(
  parameter int HEADER_BYTES = lpfd_pkg::HEADER_BYTES_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_valid,
  input  wire  [lpfd_pkg::MAX_LEN_W-1:0]       cfg_max_length,
  input  wire  [7:0]                           in_byte,
  input  lpfd_pkg::lpfd_cmd_t                  cmd,
  output lpfd_pkg::lpfd_sts_t                  sts,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 out_frame_last,
  output logic                                 out_is_error,
  output logic                                 out_error_code,
  output logic [lpfd_pkg::COUNT_W-1:0]         out_frames_done
);

  localparam int IW = $clog2(HEADER_BYTES);
  localparam int CW = lpfd_pkg::BYTE_CNT_W;
  localparam int LW = lpfd_pkg::MAX_LEN_W;
  localparam int NW = lpfd_pkg::COUNT_W;
  localparam logic [CW-1:0] HB_C    = CW'(HEADER_BYTES);
  localparam logic [31:0]   MIN_LEN = 32'(HEADER_BYTES - lpfd_pkg::LEN_OFFSET);

  logic [7:0]    hdr_mem [HEADER_BYTES];
  logic [CW-1:0] count_r, count_nxt;
  logic [NW-1:0] counter_r, counter_nxt;
  logic [LW-1:0] frame_len_r;
  logic [LW-1:0] max_len_r;
  logic [63:0]   hdr_w_r;
  logic [IW-1:0] rep_idx_r;
  logic [7:0]    rd_data_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r, out_err_r, out_code_r;
  logic [NW-1:0] out_done_r;

  logic [31:0]   len_w, magic_w;
  logic          magic_ok, len_ok, short_chk;
  logic [CW-1:0] count_inc, total;
  logic          out_load;

  assign len_w     = hdr_w_r[31:0];
  assign magic_w   = hdr_w_r[63:32];
  assign magic_ok  = (magic_w == lpfd_pkg::WIRE_MAGIC);
  assign len_ok    = (len_w >= MIN_LEN) && (len_w <= {8'd0, max_len_r});
  assign short_chk = (len_w == MIN_LEN);
  assign count_inc = count_r + CW'(1);
  // frame spans the length field plus the length value itself
  assign total     = {1'b0, frame_len_r} + CW'(lpfd_pkg::LEN_OFFSET);
  assign out_load  = cmd.err_emit | cmd.rep_emit | cmd.pass_emit;

  assign sts.hdr_full    = (count_r == HB_C - CW'(1));
  assign sts.hdr_good    = magic_ok & len_ok;
  assign sts.out_free    = ~out_valid_r | out_ready;
  assign sts.rep_last    = (rep_idx_r == IW'(HEADER_BYTES - 1));
  assign sts.short_frame = (frame_len_r == MIN_LEN[LW-1:0]);
  assign sts.pass_last   = (count_inc >= total);

  always_comb begin
    count_nxt   = count_r;
    counter_nxt = counter_r;
    if (cmd.collect_wr) begin
      count_nxt = count_inc;
    end
    if (cmd.check_ok) begin
      count_nxt = short_chk ? '0 : HB_C;
      if (short_chk) begin
        counter_nxt = counter_r + NW'(1);
      end
    end
    if (cmd.err_emit) begin
      count_nxt = '0;
    end
    if (cmd.pass_emit) begin
      count_nxt = sts.pass_last ? '0 : count_inc;
      if (sts.pass_last) begin
        counter_nxt = counter_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      counter_r   <= '0;
      max_len_r   <= lpfd_pkg::MAX_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      counter_r <= counter_nxt;
      if (cfg_valid) begin
        max_len_r <= cfg_max_length;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // header store, registered read
  always_ff @(posedge clk) begin
    if (cmd.collect_wr) begin
      hdr_mem[count_r[IW-1:0]] <= in_byte;
    end
    if (cmd.rep_rd) begin
      rd_data_r <= hdr_mem[rep_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    // length and magic words ride along in the first eight header bytes
    if (cmd.collect_wr && (count_r < CW'(8))) begin
      hdr_w_r[{count_r[2:0], 3'b000} +: 8] <= in_byte;
    end
    if (cmd.check_ok) begin
      frame_len_r <= len_w[LW-1:0];
      rep_idx_r   <= '0;
    end else if (cmd.rep_emit) begin
      rep_idx_r <= rep_idx_r + IW'(1);
    end
    if (out_load) begin
      out_done_r <= counter_nxt;
    end
    if (cmd.err_emit) begin
      out_byte_r <= '0;
      out_last_r <= 1'b0;
      out_err_r  <= 1'b1;
      out_code_r <= magic_ok ? lpfd_pkg::ERR_LENGTH : lpfd_pkg::ERR_MAGIC;
    end else if (cmd.rep_emit) begin
      out_byte_r <= rd_data_r;
      out_last_r <= sts.short_frame & sts.rep_last;
      out_err_r  <= 1'b0;
      out_code_r <= 1'b0;
    end else if (cmd.pass_emit) begin
      out_byte_r <= in_byte;
      out_last_r <= sts.pass_last;
      out_err_r  <= 1'b0;
      out_code_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_frame_last  = out_last_r;
  assign out_is_error    = out_err_r;
  assign out_error_code  = out_code_r;
  assign out_frames_done = out_done_r;

endmodule

`default_nettype wire

// ----- src/length_prefixed_frame_deframer.sv -----
// payload: an accepted payload byte enters the output register on the edge that accepts it
// throughput: header bytes are taken one per cycle, payload bytes one per cycle while the
//   output register is free; input is held during the header check and header replay,
//   and each header byte is replayed by a registered store read, then an output load
// reset: synchronous active low; clears phase, counters and the output valid, and
//   sets max_length to its largest value; the header store is not cleared
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Collects a length/magic header, checks it, replays it and passes the
// payload through with the final frame byte marked; reports header errors.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_deframer #(
  parameter int HEADER_BYTES = lpfd_pkg::HEADER_BYTES_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [lpfd_pkg::MAX_LEN_W-1:0]  cfg_max_length,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [7:0]                      in_byte,
  input  wire                             in_chunk_end,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_frame_last,
  output logic                            out_is_error,
  output logic                            out_error_code,
  output logic [lpfd_pkg::COUNT_W-1:0]    out_frames_done
);

  lpfd_pkg::lpfd_cmd_t cmd;
  lpfd_pkg::lpfd_sts_t sts;

  assign cfg_ready = 1'b1;

  lpfd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_chunk_end (in_chunk_end),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  lpfd_dp #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_max_length  (cfg_max_length),
    .in_byte         (in_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_frame_last  (out_frame_last),
    .out_is_error    (out_is_error),
    .out_error_code  (out_error_code),
    .out_frames_done (out_frames_done)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the length-prefixed frame deframer: drives header
// and payload bytes with random gaps and back-pressure, predicts every result
// request in a software copy of the deframer and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int HDR = lpfd_pkg::HEADER_BYTES_DEF;
  localparam int HW  = $clog2(HDR);

  typedef enum logic [1:0] {
    GATHER_HDR    = 2'd0,
    PASS_PAYLOAD  = 2'd1,
    DISCARD_CHUNK = 2'd2
  } deframe_phase_t;

  typedef struct packed {
    logic [7:0]                   data;
    logic                         last;
    logic                         err;
    logic                         code;
    logic [lpfd_pkg::COUNT_W-1:0] done;
  } frame_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [lpfd_pkg::MAX_LEN_W-1:0] cfg_max_length = lpfd_pkg::MAX_LEN_RST;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_byte = 8'h00;
  logic                           in_chunk_end = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [7:0]                     out_byte;
  logic                           out_frame_last;
  logic                           out_is_error;
  logic                           out_error_code;
  logic [lpfd_pkg::COUNT_W-1:0]   out_frames_done;

  length_prefixed_frame_deframer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_length  (cfg_max_length),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_chunk_end    (in_chunk_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_frame_last  (out_frame_last),
    .out_is_error    (out_is_error),
    .out_error_code  (out_error_code),
    .out_frames_done (out_frames_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // deframer state as the bench sees it
  logic [7:0]                     hdr_bytes [HDR];
  logic [24:0]                    model_count = '0;
  logic [31:0]                    model_len = '0;
  deframe_phase_t                 model_phase = GATHER_HDR;
  logic [lpfd_pkg::COUNT_W-1:0]   model_frames = '0;
  logic [lpfd_pkg::MAX_LEN_W-1:0] model_max = lpfd_pkg::MAX_LEN_RST;

  frame_result_t pending_results [$];

  int mismatches = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int header_errors = 0;
  int in_gap_pct = 0;
  int out_gap_pct = 0;
  int chunk_end_pct = 12;
  int hold_len = 0;

  function automatic void push_result(input logic [7:0] data, input logic last,
                                      input logic err, input logic code);
    frame_result_t r;
    r.data = data;
    r.last = last;
    r.err  = err;
    r.code = code;
    r.done = model_frames;
    pending_results = {pending_results, r};
  endfunction

  function automatic void predict_deframe(input logic [7:0] b, input logic ce);
    logic [31:0] len;
    logic [31:0] magic;
    logic        fin;
    case (model_phase)
      DISCARD_CHUNK: begin
        if (ce) model_phase = GATHER_HDR;
      end
      PASS_PAYLOAD: begin
        model_count = model_count + 25'd1;
        fin = ({7'd0, model_count} >= model_len + 32'd4);
        if (fin) begin
          model_frames = model_frames + 1;
          model_count = '0;
          model_phase = GATHER_HDR;
        end
        push_result(b, fin, 1'b0, lpfd_pkg::ERR_MAGIC);
      end
      default: begin
        model_phase = GATHER_HDR;
        if (model_count >= HDR) model_count = '0;
        hdr_bytes[model_count[HW-1:0]] = b;
        model_count = model_count + 25'd1;
        if (model_count == HDR) begin
          len   = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
          magic = {hdr_bytes[7], hdr_bytes[6], hdr_bytes[5], hdr_bytes[4]};
          if (magic != lpfd_pkg::WIRE_MAGIC || len < HDR - 4 ||
              len > {8'd0, model_max}) begin
            // magic mismatch wins when both checks fail
            push_result(8'h00, 1'b0, 1'b1, (magic != lpfd_pkg::WIRE_MAGIC) ?
                        lpfd_pkg::ERR_MAGIC : lpfd_pkg::ERR_LENGTH);
            header_errors++;
            model_count = '0;
            model_phase = ce ? GATHER_HDR : DISCARD_CHUNK;
          end else begin
            model_len = len;
            if (len + 4 == HDR) begin
              // frame ends with its header
              model_frames = model_frames + 1;
              for (int i = 0; i < HDR; i++)
                push_result(hdr_bytes[i], i == HDR - 1, 1'b0, lpfd_pkg::ERR_MAGIC);
              model_count = '0;
            end else begin
              for (int i = 0; i < HDR; i++)
                push_result(hdr_bytes[i], 1'b0, 1'b0, lpfd_pkg::ERR_MAGIC);
              model_phase = PASS_PAYLOAD;
            end
          end
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h (result %0d, t=%0t)",
             what, got, want, results_checked, $time);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(out_byte), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_byte !== want.data)
          report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
        if (out_frame_last !== want.last)
          report_mismatch("out_frame_last", 32'(out_frame_last), 32'(want.last));
        if (out_is_error !== want.err)
          report_mismatch("out_is_error", 32'(out_is_error), 32'(want.err));
        if (out_error_code !== want.code)
          report_mismatch("out_error_code", 32'(out_error_code), 32'(want.code));
        if (out_frames_done !== want.done)
          report_mismatch("out_frames_done", out_frames_done, want.done);
      end
      results_checked++;
    end
  end

  // receiver side: random stalls, plus long hold-offs counted down here
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_ready <= 1'b0;
      hold_len  <= hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_gap_pct);
    end
  end

  // valid stays high after acceptance; the next send or a drain decides
  task automatic send_byte(input logic [7:0] b, input logic ce);
    int gap;
    if ($urandom_range(99) < in_gap_pct) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_chunk_end <= ce;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_deframe(b, ce);
    bytes_sent++;
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [lpfd_pkg::MAX_LEN_W-1:0] v);
    drain_results();
    cfg_valid      <= 1'b1;
    cfg_max_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_max = v;
  endtask

  task automatic send_header(input logic [31:0] len, input logic [31:0] magic,
                             input logic last_ce);
    logic [7:0] b;
    logic       ce;
    for (int i = 0; i < HDR; i++) begin
      if (i < 4) b = len[8*i +: 8];
      else if (i < 8) b = magic[8*(i-4) +: 8];
      else b = 8'($urandom);
      ce = (i == HDR - 1) ? last_ce : ($urandom_range(99) < chunk_end_pct);
      send_byte(b, ce);
    end
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_byte(8'($urandom), $urandom_range(99) < chunk_end_pct);
  endtask

  task automatic send_frame(input logic [31:0] len);
    send_header(len, lpfd_pkg::WIRE_MAGIC, 1'($urandom));
    send_payload(len + 4 - HDR);
  endtask

  // bring the stream back to a header boundary, whatever state it is in
  task automatic resync;
    while (!(model_phase == GATHER_HDR && (model_count == 0 || model_count >= HDR))) begin
      case (model_phase)
        DISCARD_CHUNK: send_byte(8'($urandom), $urandom_range(3) == 0);
        PASS_PAYLOAD:  send_byte(8'($urandom), 1'($urandom));
        default:       send_byte(8'($urandom), model_count == HDR - 1);
      endcase
    end
  endtask

  task automatic test_default_limits;
    send_frame(32'd24);
    chunk_end_pct = 100;
    send_frame(32'd25);
    chunk_end_pct = 12;
    send_header(32'h0100_0000, lpfd_pkg::WIRE_MAGIC, 1'b1);
  endtask

  task automatic test_header_errors;
    // both checks fail here
    send_header(32'd0, 32'h0000_0000, 1'b0);
    repeat (5) send_byte(8'($urandom), 1'b0);
    resync();
    // error on a chunk end: the next byte starts a header straight away
    send_header(32'd50, ~lpfd_pkg::WIRE_MAGIC, 1'b1);
  endtask

  task automatic test_length_limits;
    write_max_length(24'd24);
    send_frame(32'd24);
    send_header(32'd25, lpfd_pkg::WIRE_MAGIC, 1'b1);
  endtask

  // the limit is sampled only at header completion
  task automatic test_limit_change_mid_frame;
    write_max_length(24'd40);
    send_header(32'd40, lpfd_pkg::WIRE_MAGIC, 1'b0);
    send_payload(6);
    write_max_length(24'd24);
    send_payload(10);
    write_max_length(24'hFF_FFFF);
  endtask

  task automatic test_backpressure;
    hold_len <= 400;
    repeat (2) send_frame(32'd24);
    drain_results();
  endtask

  task automatic random_traffic_segment(input int in_pct, input int out_pct,
                                        input logic [lpfd_pkg::MAX_LEN_W-1:0] limit,
                                        input int nbytes);
    int          start;
    int          pick;
    int          hi;
    logic [31:0] len;
    write_max_length(limit);
    in_gap_pct  = in_pct;
    out_gap_pct = out_pct;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) begin
      resync();
      pick = $urandom_range(99);
      hi = (model_max < 60) ? int'(model_max) : 60;
      if (pick < 5 && model_max > 60) hi = (model_max < 150) ? int'(model_max) : 150;
      if (pick < 65) begin
        send_frame($urandom_range(hi, 24));
      end else if (pick < 75) begin
        len = $urandom_range(1) ? $urandom_range(hi, 24) : $urandom;
        send_header(len, lpfd_pkg::WIRE_MAGIC ^ (32'h1 << $urandom_range(31)),
                    1'($urandom));
      end else if (pick < 85) begin
        if ($urandom_range(1)) len = $urandom_range(23, 0);
        else if (model_max != lpfd_pkg::MAX_LEN_RST) len = model_max + 1 + $urandom_range(50);
        else len = {8'($urandom_range(255, 1)), 24'($urandom)};
        send_header(len, lpfd_pkg::WIRE_MAGIC, 1'($urandom));
      end else begin
        // noise that breaks header alignment
        repeat ($urandom_range(10, 1)) send_byte(8'($urandom), $urandom_range(3) == 0);
      end
    end
    resync();
  endtask

  task automatic test_random_traffic;
    random_traffic_segment(58, 35, 24'd48, 50);
    random_traffic_segment(0, 0, 24'd200, 40);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    in_gap_pct  = 35;
    out_gap_pct = 58;
    test_default_limits();
    test_header_errors();
    test_length_limits();
    test_limit_change_mid_frame();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk);
    $display("run covered %0d input bytes and %0d checked results", bytes_sent,
             results_checked);
    $display("%0d frames completed, %0d header errors, limits 24..16777215",
             model_frames, header_errors);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results pending", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
